// ----- design/bgi_pkg.sv -----
// ----------------------------------------------------------------------------
// bgi_pkg
// Types, widths, command codes and breakpoint reset tables of the bilinear
// grid interpolator.
// ----------------------------------------------------------------------------
package bgi_pkg;

  localparam int VALUE_W     = 24;
  localparam int ROW_COORD_W = 20;
  localparam int COL_COORD_W = 16;

  // shared multiply-divide unit operand and result widths
  localparam int MD_A_W = 49;
  localparam int MD_B_W = 21;
  localparam int MD_Q_W = 64;

  typedef enum logic [1:0] {
    CMD_INTERP  = 2'd0,
    CMD_WR_GRID = 2'd1,
    CMD_WR_ROW  = 2'd2,
    CMD_WR_COL  = 2'd3
  } cmd_t;

  function automatic logic [ROW_COORD_W-1:0] row_bp_reset(input int k);
    logic [ROW_COORD_W-1:0] v;
    unique case (k)
      0:       v = ROW_COORD_W'(0);
      1:       v = ROW_COORD_W'(1049);
      2:       v = ROW_COORD_W'(4194);
      default: v = ROW_COORD_W'(20972);
    endcase
    return v;
  endfunction

  function automatic logic [COL_COORD_W-1:0] col_bp_reset(input int k);
    logic [COL_COORD_W-1:0] v;
    unique case (k)
      0:       v = COL_COORD_W'(3328);
      1:       v = COL_COORD_W'(3840);
      2:       v = COL_COORD_W'(4608);
      3:       v = COL_COORD_W'(5120);
      4:       v = COL_COORD_W'(6400);
      5:       v = COL_COORD_W'(7680);
      default: v = COL_COORD_W'(10240);
    endcase
    return v;
  endfunction

endpackage

// ----- design/bgi_if.sv -----
// ----------------------------------------------------------------------------
// bgi_if
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bgi_in_if;
  logic                                  valid;
  logic                                  ready;
  bgi_pkg::cmd_t                         command;
  logic [1:0]                            grid_select;
  logic [1:0]                            row_index;
  logic [2:0]                            column_index;
  logic signed [bgi_pkg::VALUE_W-1:0]    entry_value;
  logic [bgi_pkg::ROW_COORD_W-1:0]       row_coordinate;
  logic [bgi_pkg::COL_COORD_W-1:0]       column_coordinate;

  modport source (output valid, command, grid_select, row_index, column_index,
                  entry_value, row_coordinate, column_coordinate,
                  input ready);
  modport sink (input valid, command, grid_select, row_index, column_index,
                entry_value, row_coordinate, column_coordinate,
                output ready);
endinterface

interface bgi_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bgi_pkg::VALUE_W-1:0] interpolated_value;
  logic                               saturated;
  logic                               span_error;

  modport source (output valid, interpolated_value, saturated, span_error,
                  input ready);
  modport sink (input valid, interpolated_value, saturated, span_error,
                output ready);
endinterface

// ----- design/bilinear_grid_interpolator.sv -----
// ----------------------------------------------------------------------------
// bilinear_grid_interpolator
// Bilinear interpolation over stored value grids on non-uniform row and
// column breakpoint axes, with linear extrapolation and result saturation.
// ----------------------------------------------------------------------------
// in_ch carries commands: interpolate, write grid value, write row
// breakpoint, write column breakpoint. out_ch returns one result per
// command; write commands return all zero fields.
// A write command or an interpolate with an unused grid_select has its result
// valid the cycle after the transfer.
// An interpolate scans both axes one breakpoint a cycle, fetches the four
// corner values from the grid RAM, then runs three multiply-divide steps on
// the shared unit (bit-serial shift-add multiply over the 21 multiplier bits,
// then restoring divide over the 64 quotient bits). A zero row or column span
// ends it early with span_error set and a zero result. in_ch is not ready
// while an interpolate is in progress.
// Reset loads the default breakpoints and empties the output register; grid
// values are undefined until written.
// A stalled out_ch holds its result; a new command is taken once the
// pending result is transferred or in the same cycle.
// ----------------------------------------------------------------------------
module bilinear_grid_interpolator #(
  parameter int ROW_POINTS    = 4,
  parameter int COLUMN_POINTS = 7,
  parameter int GRID_COUNT    = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  bgi_in_if.sink     in_ch,
  bgi_out_if.source  out_ch
);

  localparam int VW     = bgi_pkg::VALUE_W;
  localparam int ZW     = bgi_pkg::ROW_COORD_W;
  localparam int MW     = bgi_pkg::COL_COORD_W;
  localparam int BW     = bgi_pkg::MD_B_W;
  localparam int AW     = bgi_pkg::MD_A_W;
  localparam int QW     = bgi_pkg::MD_Q_W;
  localparam int PW     = 48;
  localparam int RW     = QW + 1;
  localparam int RI_W   = $clog2(ROW_POINTS);
  localparam int CI_W   = $clog2(COLUMN_POINTS);
  localparam int DEPTH  = GRID_COUNT * ROW_POINTS * COLUMN_POINTS;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_RSCAN, S_RLO, S_RHI, S_CSCAN, S_CLO, S_CHI, S_CHECK,
    S_READ, S_OP, S_WAIT, S_FIN
  } state_t;

  state_t                  state_r;
  logic [ZW-1:0]           row_bp_r [ROW_POINTS];
  logic [MW-1:0]           col_bp_r [COLUMN_POINTS];
  logic [1:0]              g_r;
  logic [ZW-1:0]           z_r;
  logic [MW-1:0]           m_r;
  logic [RI_W-1:0]         rk_r;
  logic [CI_W-1:0]         ck_r;
  logic [RI_W-1:0]         i_r;
  logic [CI_W-1:0]         j_r;
  logic [ZW-1:0]           rlo_r;
  logic [MW-1:0]           clo_r;
  logic signed [BW-1:0]    rspan_r;
  logic signed [BW-1:0]    zd_r;
  logic signed [BW-1:0]    cspan_r;
  logic signed [BW-1:0]    md_r;
  logic [2:0]              rc_r;
  logic [1:0]              op_r;
  logic signed [VW-1:0]    v_r [4];
  logic signed [PW-1:0]    p1_r;
  logic signed [PW-1:0]    p2_r;
  logic signed [RW-1:0]    res_r;
  logic                    err_r;
  logic                    out_valid_r;
  logic signed [VW-1:0]    out_value_r;
  logic                    out_sat_r;
  logic                    out_err_r;

  logic                    accept;
  logic                    out_free;
  logic                    out_load;
  logic                    grid_ok;
  logic [RI_W-1:0]         row_sel;
  logic [CI_W-1:0]         col_sel;
  logic [ZW-1:0]           row_bp_rd;
  logic [MW-1:0]           col_bp_rd;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [VW-1:0]           ram_rdata;
  logic                    md_start;
  logic signed [AW-1:0]    md_a;
  logic signed [BW-1:0]    md_b;
  logic signed [BW-1:0]    md_d;
  logic                    md_done;
  logic signed [QW-1:0]    md_q;
  logic                    res_hi_ok;

  function automatic logic [ADDR_W-1:0] grid_addr(input int g, input int r, input int c);
    return ADDR_W'((g * ROW_POINTS + r) * COLUMN_POINTS + c);
  endfunction

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign grid_ok      = int'(in_ch.grid_select) < GRID_COUNT;
  assign out_load     = (accept && !(in_ch.command == bgi_pkg::CMD_INTERP && grid_ok))
                        || (state_r == S_FIN && out_free);

  assign out_ch.valid              = out_valid_r;
  assign out_ch.interpolated_value = out_value_r;
  assign out_ch.saturated          = out_sat_r;
  assign out_ch.span_error         = out_err_r;

  // single read mux per axis
  always_comb begin
    unique case (state_r)
      S_RLO:   row_sel = i_r - RI_W'(1);
      S_RHI:   row_sel = i_r;
      default: row_sel = rk_r;
    endcase
    unique case (state_r)
      S_CLO:   col_sel = j_r - CI_W'(1);
      S_CHI:   col_sel = j_r;
      default: col_sel = ck_r;
    endcase
  end
  assign row_bp_rd = row_bp_r[row_sel];
  assign col_bp_rd = col_bp_r[col_sel];

  // grid RAM
  assign ram_we = accept && (in_ch.command == bgi_pkg::CMD_WR_GRID) && grid_ok
                  && (int'(in_ch.row_index) < ROW_POINTS)
                  && (int'(in_ch.column_index) < COLUMN_POINTS);
  assign ram_waddr = grid_addr(int'(in_ch.grid_select), int'(in_ch.row_index),
                               int'(in_ch.column_index));
  assign ram_raddr = grid_addr(int'(g_r),
                               rc_r[0] ? int'(i_r) : int'(i_r) - 1,
                               rc_r[1] ? int'(j_r) : int'(j_r) - 1);

  bgi_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.entry_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // operand select for the shared unit
  always_comb begin
    unique case (op_r)
      2'd0:    md_a = AW'(v_r[1]) - AW'(v_r[0]);
      2'd1:    md_a = AW'(v_r[3]) - AW'(v_r[2]);
      default: md_a = AW'(p2_r) - AW'(p1_r);
    endcase
    md_b = (op_r == 2'd2) ? md_r : zd_r;
    md_d = (op_r == 2'd2) ? cspan_r : rspan_r;
  end
  assign md_start = (state_r == S_OP);

  bgi_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .d     (md_d),
    .done  (md_done),
    .q     (md_q)
  );

  assign res_hi_ok = (&res_r[RW-1:VW-1]) || !(|res_r[RW-1:VW-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < ROW_POINTS; k++) begin
        row_bp_r[k] <= bgi_pkg::row_bp_reset(k);
      end
      for (int k = 0; k < COLUMN_POINTS; k++) begin
        col_bp_r[k] <= bgi_pkg::col_bp_reset(k);
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            for (int k = 0; k < ROW_POINTS; k++) begin
              if (in_ch.command == bgi_pkg::CMD_WR_ROW && int'(in_ch.row_index) == k) begin
                row_bp_r[k] <= in_ch.row_coordinate;
              end
            end
            for (int k = 0; k < COLUMN_POINTS; k++) begin
              if (in_ch.command == bgi_pkg::CMD_WR_COL
                  && int'(in_ch.column_index) == k) begin
                col_bp_r[k] <= in_ch.column_coordinate;
              end
            end
            g_r   <= in_ch.grid_select;
            z_r   <= in_ch.row_coordinate;
            m_r   <= in_ch.column_coordinate;
            rk_r  <= '0;
            ck_r  <= '0;
            rc_r  <= '0;
            op_r  <= '0;
            err_r <= 1'b0;
            if (in_ch.command == bgi_pkg::CMD_INTERP && grid_ok) begin
              state_r <= S_RSCAN;
            end else begin
              out_value_r <= '0;
              out_sat_r   <= 1'b0;
              out_err_r   <= 1'b0;
            end
          end
        end
        S_RSCAN: begin
          if (rk_r == RI_W'(ROW_POINTS-1) || z_r < row_bp_rd) begin
            i_r     <= (rk_r == '0) ? RI_W'(1) : rk_r;
            state_r <= S_RLO;
          end else begin
            rk_r <= rk_r + RI_W'(1);
          end
        end
        S_RLO: begin
          rlo_r   <= row_bp_rd;
          state_r <= S_RHI;
        end
        S_RHI: begin
          rspan_r <= BW'({1'b0, row_bp_rd}) - BW'({1'b0, rlo_r});
          zd_r    <= BW'({1'b0, z_r}) - BW'({1'b0, rlo_r});
          state_r <= S_CSCAN;
        end
        S_CSCAN: begin
          if (ck_r == CI_W'(COLUMN_POINTS-1) || m_r < col_bp_rd) begin
            j_r     <= (ck_r == '0) ? CI_W'(1) : ck_r;
            state_r <= S_CLO;
          end else begin
            ck_r <= ck_r + CI_W'(1);
          end
        end
        S_CLO: begin
          clo_r   <= col_bp_rd;
          state_r <= S_CHI;
        end
        S_CHI: begin
          cspan_r <= BW'({1'b0, col_bp_rd}) - BW'({1'b0, clo_r});
          md_r    <= BW'({1'b0, m_r}) - BW'({1'b0, clo_r});
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (rspan_r == '0 || cspan_r == '0) begin
            err_r   <= 1'b1;
            state_r <= S_FIN;
          end else begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (rc_r != '0) begin
            v_r[rc_r[1:0] - 2'd1] <= ram_rdata;
          end
          if (rc_r == 3'd4) begin
            state_r <= S_OP;
          end else begin
            rc_r <= rc_r + 3'd1;
          end
        end
        S_OP: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (md_done) begin
            unique case (op_r)
              2'd0: begin
                p1_r    <= PW'(v_r[0]) + PW'(md_q);
                op_r    <= 2'd1;
                state_r <= S_OP;
              end
              2'd1: begin
                p2_r    <= PW'(v_r[2]) + PW'(md_q);
                op_r    <= 2'd2;
                state_r <= S_OP;
              end
              default: begin
                res_r   <= RW'(p1_r) + RW'(md_q);
                state_r <= S_FIN;
              end
            endcase
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (err_r) begin
              out_value_r <= '0;
              out_sat_r   <= 1'b0;
              out_err_r   <= 1'b1;
            end else begin
              out_err_r <= 1'b0;
              out_sat_r <= !res_hi_ok;
              if (res_hi_ok) begin
                out_value_r <= res_r[VW-1:0];
              end else if (res_r[RW-1]) begin
                out_value_r <= {1'b1, {(VW-1){1'b0}}};
              end else begin
                out_value_r <= {1'b0, {(VW-1){1'b1}}};
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE)
    else $error("ready outside idle");

  a_span_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_value_r == '0 && !out_sat_r)
    else $error("span error with nonzero result");

  a_unit_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> state_r == S_WAIT)
    else $error("unit finished outside wait");

  a_interp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.command == bgi_pkg::CMD_INTERP && grid_ok |=> !in_ch.ready)
    else $error("ready right after interpolate transfer");

endmodule

// ----- design/bgi_ram.sv -----
// ----------------------------------------------------------------------------
// bgi_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bgi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 112
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bgi_muldiv.sv -----
// ----------------------------------------------------------------------------
// bgi_muldiv
// Shared unit: q = a * b / d, truncated toward zero. Shift-add multiply,
// one bit per cycle, then restoring divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgi_muldiv (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [bgi_pkg::MD_A_W-1:0]  a,
  input  logic signed [bgi_pkg::MD_B_W-1:0]  b,
  input  logic signed [bgi_pkg::MD_B_W-1:0]  d,
  output logic                               done,
  output logic signed [bgi_pkg::MD_Q_W-1:0]  q
);

  localparam int AW  = bgi_pkg::MD_A_W;
  localparam int BW  = bgi_pkg::MD_B_W;
  localparam int QW  = bgi_pkg::MD_Q_W;
  localparam int CW  = $clog2(QW);

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_DONE} md_state_t;

  md_state_t       state_r;
  logic [CW-1:0]   cnt_r;
  logic [QW-1:0]   acc_r;
  logic [QW-1:0]   mcand_r;
  logic [BW-1:0]   mplier_r;
  logic [BW-1:0]   dv_r;
  logic [BW-1:0]   rem_r;
  logic            neg_r;

  logic [AW-1:0]   a_mag;
  logic [BW-1:0]   b_mag;
  logic [BW-1:0]   d_mag;
  logic [BW:0]     rem_sh;
  logic            ge;
  logic [BW:0]     rem_sub;

  assign a_mag   = a[AW-1] ? AW'(-a) : AW'(a);
  assign b_mag   = b[BW-1] ? BW'(-b) : BW'(b);
  assign d_mag   = d[BW-1] ? BW'(-d) : BW'(d);
  assign rem_sh  = {rem_r, acc_r[QW-1]};
  assign ge      = rem_sh >= {1'b0, dv_r};
  assign rem_sub = rem_sh - {1'b0, dv_r};

  assign done = (state_r == MD_DONE);
  assign q    = neg_r ? -$signed(acc_r) : $signed(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
    end else begin
      unique case (state_r)
        MD_IDLE: begin
          if (start) begin
            acc_r    <= '0;
            mcand_r  <= QW'(a_mag);
            mplier_r <= b_mag;
            dv_r     <= d_mag;
            rem_r    <= '0;
            neg_r    <= (a[AW-1] ^ b[BW-1]) ^ d[BW-1];
            cnt_r    <= '0;
            state_r  <= MD_MUL;
          end
        end
        MD_MUL: begin
          if (mplier_r[0]) begin
            acc_r <= acc_r + mcand_r;
          end
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          if (cnt_r == CW'(BW-1)) begin
            cnt_r   <= '0;
            state_r <= MD_DIV;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        MD_DIV: begin
          rem_r <= ge ? rem_sub[BW-1:0] : rem_sh[BW-1:0];
          acc_r <= {acc_r[QW-2:0], ge};
          if (cnt_r == CW'(QW-1)) begin
            state_r <= MD_DONE;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        MD_DONE: begin
          state_r <= MD_IDLE;
        end
        default: state_r <= MD_IDLE;
      endcase
    end
  end

endmodule
